@@ rtl/core/ultrasonic_echo_ranger_assert.svh @@
// assertion macros for the ultrasonic echo ranger
// expects signals named clock and reset in the scope of each use
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

`ifndef SYNTHESIS

`define URE_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ure assertion failed");

`define URE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ure assertion failed");

`else

`define URE_ASSERT_IMPL(label, ante, cons)

`define URE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/ure_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the ultrasonic echo ranger
// no dependencies
package ure_pkg;

   localparam int NOW_W  = 32;
   localparam int CAP_W  = 16;
   localparam int CFG_W  = 16;
   localparam int DIST_W = 11;
   localparam int IDX_W  = 2;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RISE = 2'd1,
      PH_FALL = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      FUNC_TICK = 2'd0,
      FUNC_EDGE = 2'd1,
      FUNC_TAKE = 2'd2
   } func_type;

   localparam logic [IDX_W-1:0] CSR_PERIOD  = 2'd0;
   localparam logic [IDX_W-1:0] CSR_TIMEOUT = 2'd1;
   localparam logic [IDX_W-1:0] CSR_MAX_ECHO = 2'd2;

   localparam logic [CFG_W-1:0] PERIOD_RESET   = 16'd100;
   localparam logic [CFG_W-1:0] TIMEOUT_RESET  = 16'd50;
   localparam logic [CFG_W-1:0] MAX_ECHO_RESET = 16'd25000;

   // width / 58 as (width * 72316) >> 22, exact for 16-bit widths
   localparam int DIV_SHIFT = 22;
   localparam int DIV_MUL_W = 17;
   localparam int PROD_W    = CAP_W + DIV_MUL_W;
   localparam logic [DIV_MUL_W-1:0] DIV_MULT = 17'd72316;

   typedef struct packed {
      logic [CFG_W-1:0] period;
      logic [CFG_W-1:0] timeout;
      logic [CFG_W-1:0] max_echo;
   } cfg_type;

   typedef struct packed {
      logic              trigger_fire;
      logic              capture_on_falling;
      logic [1:0]        phase;
      logic [DIST_W-1:0] distance_cm;
      logic              reading_taken;
      logic              new_reading;
   } rsp_type;

endpackage

@@ rtl/core/ure_if.sv @@
`timescale 1ns / 1ps
// channel interfaces for the ultrasonic echo ranger: request, response, csr write
// depends on ure_pkg
interface ure_req_if import ure_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       func;
   logic [NOW_W-1:0] now_ms;
   logic [CAP_W-1:0] captured_us;

   modport source (output valid, func, now_ms, captured_us, input ready);
   modport sink (input valid, func, now_ms, captured_us, output ready);
endinterface

interface ure_rsp_if import ure_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              trigger_fire;
   logic              capture_on_falling;
   logic [1:0]        phase;
   logic [DIST_W-1:0] distance_cm;
   logic              reading_taken;
   logic              new_reading;

   modport source (output valid, trigger_fire, capture_on_falling, phase, distance_cm,
                   reading_taken, new_reading, input ready);
   modport sink (input valid, trigger_fire, capture_on_falling, phase, distance_cm,
                 reading_taken, new_reading, output ready);
endinterface

interface ure_csr_if import ure_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [CFG_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/ultrasonic_echo_ranger.sv @@
`timescale 1ns / 1ps
// ultrasonic echo ranger top level: request register, sequencer core, response register
// depends on ure_pkg, ure_if, ure_csr, ure_core and ultrasonic_echo_ranger_assert.svh
//
// usage:
//   req_chan carries one transaction per event: func 0 a millisecond tick (now_ms),
//   func 1 a captured echo edge (captured_us), func 2 a take of the fresh flag
//   rsp_chan returns exactly one transaction per request, in order
//   csr_chan writes period, timeout and max echo width, index 0 to 2; other
//   indices are ignored; csr_chan is always ready
// timing:
//   a request is held in the request register and then in the response register
//   throughput is one transaction per cycle while rsp_chan is not stalled; the
//   request register and the response register each hold one transaction, and the
//   sequencer state is updated in the cycle a transaction moves from one to the other
// reset:
//   phase idle, distance and fresh flag zero, last trigger time zero,
//   registers at period 100, timeout 50, max echo 25000
// backpressure:
//   while rsp_chan is stalled the response holds, the request register fills
//   and then req_chan ready drops; nothing is lost or repeated
`include "ultrasonic_echo_ranger_assert.svh"

module ultrasonic_echo_ranger import ure_pkg::*; #(
   parameter int CAPTURE_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   ure_req_if.sink     req_chan,
   ure_rsp_if.source   rsp_chan,
   ure_csr_if.sink     csr_chan
);

   logic             in_valid_ff, in_valid_in;
   logic [1:0]       func_ff;
   logic [NOW_W-1:0] now_ff;
   logic [CAP_W-1:0] cap_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          result;
   cfg_type          cfg;
   logic             advance, go, req_accept;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign go             = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   ure_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid && csr_chan.ready),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   ure_core #(
      .CAPTURE_BITS (CAPTURE_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .func        (func_ff),
      .now_ms      (now_ff),
      .captured_us (cap_ff),
      .cfg         (cfg),
      .result      (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff <= req_chan.func;
         now_ff  <= req_chan.now_ms;
         cap_ff  <= req_chan.captured_us;
      end
      if (go) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.trigger_fire       = rsp_ff.trigger_fire;
   assign rsp_chan.capture_on_falling = rsp_ff.capture_on_falling;
   assign rsp_chan.phase              = rsp_ff.phase;
   assign rsp_chan.distance_cm        = rsp_ff.distance_cm;
   assign rsp_chan.reading_taken      = rsp_ff.reading_taken;
   assign rsp_chan.new_reading        = rsp_ff.new_reading;

   `URE_ASSERT_IMPL(a_fire_arms_rise, rsp_chan.valid && rsp_chan.trigger_fire,
                    rsp_chan.phase == PH_RISE)
   `URE_ASSERT_IMPL(a_new_reading_idle, rsp_chan.valid && rsp_chan.new_reading,
                    rsp_chan.phase == PH_IDLE && !rsp_chan.trigger_fire)
   `URE_ASSERT_IMPL(a_polarity_phase, rsp_chan.valid,
                    rsp_chan.capture_on_falling == (rsp_chan.phase == PH_FALL))
   `URE_ASSERT_NEXT(a_request_held, in_valid_ff && !advance, in_valid_ff && $stable(func_ff))

endmodule

@@ rtl/core/ure_csr.sv @@
`timescale 1ns / 1ps
// configuration registers of the ultrasonic echo ranger
// depends on ure_pkg
module ure_csr import ure_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_index,
   input  logic [CFG_W-1:0] wr_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_PERIOD:   cfg_in.period   = wr_data;
            CSR_TIMEOUT:  cfg_in.timeout  = wr_data;
            CSR_MAX_ECHO: cfg_in.max_echo = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period   <= PERIOD_RESET;
         cfg_ff.timeout  <= TIMEOUT_RESET;
         cfg_ff.max_echo <= MAX_ECHO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/ure_core.sv @@
`timescale 1ns / 1ps
// ranging sequencer state and per-transaction next-state logic
// depends on ure_pkg
module ure_core import ure_pkg::*; #(
   parameter int CAPTURE_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [1:0]       func,
   input  logic [NOW_W-1:0] now_ms,
   input  logic [CAP_W-1:0] captured_us,
   input  cfg_type          cfg,
   output rsp_type          result
);

   localparam int CmpW = (CAPTURE_BITS > CFG_W) ? CAPTURE_BITS : CFG_W;

   phase_type                phase_ff, phase_in;
   logic [CAPTURE_BITS-1:0]  start_ff, start_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic                     fresh_ff, fresh_in;
   logic [NOW_W-1:0]         trig_ff, trig_in;

   logic [CAPTURE_BITS-1:0]  cap;
   logic [CAPTURE_BITS-1:0]  width;
   logic [NOW_W-1:0]         elapsed;
   logic                     in_range;
   logic                     active;
   logic [PROD_W-1:0]        prod;
   logic                     fire, taken, fresh_now;

   assign cap      = CAPTURE_BITS'(captured_us);
   assign width    = cap - start_ff;
   assign elapsed  = now_ms - trig_ff;
   assign in_range = CmpW'(width) < CmpW'(cfg.max_echo);
   assign prod     = PROD_W'(CAP_W'(width)) * PROD_W'(DIV_MULT);
   assign active   = (phase_ff == PH_RISE) || (phase_ff == PH_FALL);

   always_comb begin
      phase_in  = phase_ff;
      start_in  = start_ff;
      dist_in   = dist_ff;
      fresh_in  = fresh_ff;
      trig_in   = trig_ff;
      fire      = 1'b0;
      taken     = 1'b0;
      fresh_now = 1'b0;
      case (func_type'(func))
         FUNC_TICK: begin
            if (!active) begin
               if (elapsed >= NOW_W'(cfg.period)) begin
                  trig_in  = now_ms;
                  phase_in = PH_RISE;
                  fire     = 1'b1;
               end
            end else if (elapsed >= NOW_W'(cfg.timeout)) begin
               phase_in = PH_IDLE;
            end
         end
         FUNC_EDGE: begin
            case (phase_ff)
               PH_RISE: begin
                  start_in = cap;
                  phase_in = PH_FALL;
               end
               PH_FALL: begin
                  phase_in = PH_IDLE;
                  if (in_range) begin
                     dist_in   = prod[DIV_SHIFT +: DIST_W];
                     fresh_in  = 1'b1;
                     fresh_now = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         FUNC_TAKE: begin
            taken    = fresh_ff;
            fresh_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_comb begin
      result.trigger_fire       = fire;
      result.capture_on_falling = (phase_in == PH_FALL);
      result.phase              = phase_in;
      result.distance_cm        = dist_in;
      result.reading_taken      = taken;
      result.new_reading        = fresh_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         start_ff <= '0;
         dist_ff  <= '0;
         fresh_ff <= 1'b0;
         trig_ff  <= '0;
      end else if (go) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         dist_ff  <= dist_in;
         fresh_ff <= fresh_in;
         trig_ff  <= trig_in;
      end
   end

endmodule
